[hdl/pft_pkg.sv]
// shared constants and types for the pulse flow totalizer
package pft_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(HIST_DEPTH);

  localparam int CNT_W  = 16;
  localparam int TICK_W = 32;
  localparam int VOL_W  = 32;
  localparam int PPL_W  = 16;
  localparam int FLOW_W = 32;

  localparam logic [PPL_W-1:0] DEFAULT_PPL = PPL_W'(500);
  localparam int ML_PER_L   = 1000;
  localparam int FLOW_SCALE = 60000000;

  localparam int ACC_W   = $clog2((2**CNT_W - 1) * ML_PER_L + 2**PPL_W - 1);
  localparam int SUM_W   = CNT_W + $clog2(HIST_DEPTH);
  localparam int SCALE_W = $clog2(FLOW_SCALE + 1);
  localparam int NUM_W   = SUM_W + SCALE_W;
  localparam int DEN_W   = PPL_W + TICK_W;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PPL    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET = CFG_IDX_W'(1);

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

[hdl/pulse_flow_totalizer_top.sv]
// top level of the pulse flow totalizer: sequencer, history ring and output register
//
// Each accepted sample gives one result. A sample is accepted only while the sequencer
// is idle, and the work runs through one shared divider that yields one quotient bit
// per cycle. Until the history ring holds HIST_DEPTH samples a sample runs only the
// volume division; once the ring is full the flow division follows the volume
// division, and is skipped when the interval is zero. A new sample may be accepted
// while the previous result still waits at the output.
// Configuration writes are taken at any time but must only be issued while idle.
module pulse_flow_totalizer_top import pft_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CNT_W-1:0]      counter_value_i,
  input  logic [TICK_W-1:0]     tick_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  pulses_seen_o,
  output logic [CNT_W-1:0]      pulse_delta_o,
  output logic [VOL_W-1:0]      total_ml_o,
  output logic [FLOW_W-1:0]     flow_ml_per_min_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_VREQ,
    S_VWAIT,
    S_MUL,
    S_FREQ,
    S_FWAIT,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [PPL_W-1:0]  ppl_cfg_q, ppl_cfg_d;
  logic [PPL_W-1:0]  ppl_q, ppl_d;
  logic [CNT_W-1:0]  last_q, last_d;
  logic [VOL_W-1:0]  volume_q, volume_d;
  logic [PPL_W-1:0]  carry_q, carry_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  fill_q, fill_d;
  logic              full_q, full_d;
  logic [CNT_W-1:0]  delta_q, delta_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [FLOW_W-1:0] flow_res_q, flow_res_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  out_delta_q, out_delta_d;
  logic [VOL_W-1:0]  out_total_q, out_total_d;
  logic [FLOW_W-1:0] out_flow_q, out_flow_d;

  logic                in_accept;
  logic                cfg_accept;
  logic [CNT_W-1:0]    delta_new;
  logic [IDX_W:0]      slot_sum;
  logic [IDX_W-1:0]    slot;
  logic [TICK_W-1:0]   dt;
  logic [TICK_W+CNT_W-1:0] ring_rdata;
  logic [TICK_W-1:0]   old_tick;
  logic [CNT_W-1:0]    old_delta;

  div_req_t          div_req;
  logic [NUM_W-1:0]  div_dividend;
  logic [DEN_W-1:0]  div_divisor;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_rem;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;

  assign delta_new = counter_value_i - last_q;
  assign slot_sum  = {1'b0, head_q} + {1'b0, fill_q};
  assign slot      = (slot_sum >= (IDX_W+1)'(HIST_DEPTH))
                   ? IDX_W'(slot_sum - (IDX_W+1)'(HIST_DEPTH)) : slot_sum[IDX_W-1:0];

  assign old_tick  = ring_rdata[TICK_W+CNT_W-1:CNT_W];
  assign old_delta = ring_rdata[CNT_W-1:0];
  assign dt        = tick_q - old_tick;

  pft_ram #(
    .WIDTH(TICK_W + CNT_W),
    .DEPTH(HIST_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (slot),
    .wdata_i ({tick_ms_i, delta_new}),
    .re_i    (in_accept),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  always_comb begin
    div_req.start = (state_q == S_VREQ) || (state_q == S_FREQ);
    div_req.steps = (state_q == S_FREQ) ? STEP_W'(NUM_W) : STEP_W'(ACC_W);
    if (state_q == S_FREQ) begin
      div_dividend = num_q;
      div_divisor  = den_q;
    end else begin
      div_dividend = NUM_W'(acc_q) << (NUM_W - ACC_W);
      div_divisor  = DEN_W'(ppl_q);
    end
  end

  pft_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    ppl_cfg_d   = ppl_cfg_q;
    ppl_d       = ppl_q;
    last_d      = last_q;
    volume_d    = volume_q;
    carry_d     = carry_q;
    sum_d       = sum_q;
    head_d      = head_q;
    fill_d      = fill_q;
    full_d      = full_q;
    delta_d     = delta_q;
    tick_d      = tick_q;
    acc_d       = acc_q;
    num_d       = num_q;
    den_d       = den_q;
    flow_res_d  = flow_res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_delta_d = out_delta_q;
    out_total_d = out_total_q;
    out_flow_d  = out_flow_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          last_d  = counter_value_i;
          delta_d = delta_new;
          tick_d  = tick_ms_i;
          ppl_d   = (ppl_cfg_q == '0) ? DEFAULT_PPL : ppl_cfg_q;
          sum_d   = sum_q + SUM_W'(delta_new);
          acc_d   = ACC_W'(carry_q) + ACC_W'(delta_new) * ACC_W'(ML_PER_L);
          full_d  = (fill_q == IDX_W'(HIST_DEPTH - 1));
          if (fill_q != IDX_W'(HIST_DEPTH - 1)) begin
            fill_d = fill_q + IDX_W'(1);
          end
          state_d = S_VREQ;
        end
      end
      S_VREQ: begin
        state_d = S_VWAIT;
      end
      S_VWAIT: begin
        if (div_done) begin
          volume_d = volume_q + VOL_W'(div_quo[ACC_W-1:0]);
          carry_d  = div_rem[PPL_W-1:0];
          if (full_q) begin
            state_d = S_MUL;
          end else begin
            flow_res_d = '0;
            state_d    = S_DONE;
          end
        end
      end
      S_MUL: begin
        num_d  = NUM_W'(sum_q) * NUM_W'(FLOW_SCALE);
        den_d  = DEN_W'(ppl_q) * DEN_W'(dt);
        sum_d  = sum_q - SUM_W'(old_delta);
        head_d = (head_q == IDX_W'(HIST_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
        if (dt == '0) begin
          flow_res_d = '1;
          state_d    = S_DONE;
        end else begin
          state_d = S_FREQ;
        end
      end
      S_FREQ: begin
        state_d = S_FWAIT;
      end
      S_FWAIT: begin
        if (div_done) begin
          flow_res_d = (|div_quo[NUM_W-1:FLOW_W]) ? '1 : div_quo[FLOW_W-1:0];
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_delta_d = delta_q;
          out_total_d = volume_q;
          out_flow_d  = flow_res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_accept) begin
      if (cfg_index_i == CFG_PPL) begin
        ppl_cfg_d = cfg_data_i[PPL_W-1:0];
      end else if (cfg_index_i == CFG_PRESET) begin
        volume_d = cfg_data_i[VOL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ppl_cfg_q   <= '0;
      last_q      <= '0;
      volume_q    <= '0;
      carry_q     <= '0;
      sum_q       <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ppl_q       <= '0;
      delta_q     <= '0;
      tick_q      <= '0;
      acc_q       <= '0;
      num_q       <= '0;
      den_q       <= '0;
      flow_res_q  <= '0;
      out_delta_q <= '0;
      out_total_q <= '0;
      out_flow_q  <= '0;
    end else begin
      state_q     <= state_d;
      ppl_cfg_q   <= ppl_cfg_d;
      last_q      <= last_d;
      volume_q    <= volume_d;
      carry_q     <= carry_d;
      sum_q       <= sum_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      ppl_q       <= ppl_d;
      delta_q     <= delta_d;
      tick_q      <= tick_d;
      acc_q       <= acc_d;
      num_q       <= num_d;
      den_q       <= den_d;
      flow_res_q  <= flow_res_d;
      out_delta_q <= out_delta_d;
      out_total_q <= out_total_d;
      out_flow_q  <= out_flow_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pulses_seen_o     = |out_delta_q;
  assign pulse_delta_o     = out_delta_q;
  assign total_ml_o        = out_total_q;
  assign flow_ml_per_min_o = out_flow_q;

endmodule

[hdl/pft_ram.sv]
// generic single write port ram with registered read
module pft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/pft_div.sv]
// shared radix-2 restoring divider, one quotient bit per cycle
module pft_div import pft_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DEN_W-1:0]  rem_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  dvs_q;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[bench/pulse_flow_totalizer_top_test.sv]
// self-checking testbench for the pulse flow totalizer: directed table, then random samples
module pulse_flow_totalizer_top_test import pft_pkg::*;;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic              seen;
    logic [CNT_W-1:0]  delta;
    logic [VOL_W-1:0]  total;
    logic [FLOW_W-1:0] flow;
  } reading_t;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          word;
    logic [CNT_W-1:0]     count;
    logic                 typed;
    reading_t             want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [CNT_W-1:0]      counter_value_i = '0;
  logic [TICK_W-1:0]     tick_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  pulses_seen_o;
  logic [CNT_W-1:0]      pulse_delta_o;
  logic [VOL_W-1:0]      total_ml_o;
  logic [FLOW_W-1:0]     flow_ml_per_min_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pulse_flow_totalizer_top u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow state of the totalizer
  logic [PPL_W-1:0]  ppl_setting = '0;
  logic [CNT_W-1:0]  last_count = '0;
  logic [VOL_W-1:0]  volume = '0;
  logic [31:0]       carry = '0;
  logic [31:0]       window_sum = '0;
  logic [TICK_W-1:0] ring_ticks [HIST_DEPTH];
  logic [CNT_W-1:0]  ring_deltas [HIST_DEPTH];
  int                ring_fill = 0;
  int                ring_head = 0;

  reading_t  pending_readings [$];
  plan_row_t plan [$];
  int        mismatch_count = 0;
  bit        calm = 1'b0;

  function automatic reading_t totalize(input logic [CNT_W-1:0] count,
                                        input logic [TICK_W-1:0] tick);
    logic [CNT_W-1:0] delta;
    logic [31:0]      ppl;
    logic [31:0]      acc;
    logic [31:0]      whole;
    logic [31:0]      dt;
    logic [63:0]      num;
    logic [63:0]      den;
    logic [63:0]      quot;
    int               slot;
    reading_t         r;
    ppl = (ppl_setting == '0) ? 32'(DEFAULT_PPL) : 32'(ppl_setting);
    delta = count - last_count;
    last_count = count;
    slot = (ring_head + ring_fill) % HIST_DEPTH;
    ring_ticks[slot] = tick;
    ring_deltas[slot] = delta;
    if (ring_fill < HIST_DEPTH) ring_fill++;
    window_sum += 32'(delta);
    acc = carry + 32'(delta) * 32'(ML_PER_L);
    whole = acc / ppl;
    carry = acc - whole * ppl;
    volume += whole;
    r.flow = '0;
    if (ring_fill == HIST_DEPTH) begin
      dt = tick - ring_ticks[ring_head];
      if (dt == 0) begin
        r.flow = '1;
      end else begin
        num = 64'(window_sum) * 64'(FLOW_SCALE);
        den = 64'(ppl) * 64'(dt);
        quot = num / den;
        r.flow = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
      end
      window_sum -= 32'(ring_deltas[ring_head]);
      ring_head = (ring_head + 1) % HIST_DEPTH;
      ring_fill--;
    end
    r.seen = (delta != '0);
    r.delta = delta;
    r.total = volume;
    return r;
  endfunction

  task automatic pause_sender();
    if (!calm) begin
      while ($urandom_range(99) < 17) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  task automatic offer_sample(input logic [CNT_W-1:0] count, input logic [TICK_W-1:0] tick,
                              input logic typed, input reading_t want);
    reading_t predicted;
    in_valid_i <= 1'b1;
    counter_value_i <= count;
    tick_ms_i <= tick;
    do @(posedge clk_i); while (in_stall_o);
    predicted = totalize(count, tick);
    pending_readings.push_back(typed ? want : predicted);
    pause_sender();
  endtask

  // stop sending until every result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_readings.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CFG_PPL) ppl_setting = data[PPL_W-1:0];
    else if (index == CFG_PRESET) volume = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 17);

  always @(posedge clk_i) begin : result_check
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transaction, expected none, actual delta %0h total %0h",
                 $time, pulse_delta_o, total_ml_o);
      end else begin
        want = pending_readings.pop_front();
        compare_field("pulses_seen", 32'(want.seen), 32'(pulses_seen_o));
        compare_field("pulse_delta", 32'(want.delta), 32'(pulse_delta_o));
        compare_field("total_ml", want.total, total_ml_o);
        compare_field("flow_ml_per_min", want.flow, flow_ml_per_min_o);
      end
    end
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [CNT_W-1:0]  meter_count;
    logic [TICK_W-1:0] meter_tick;
    logic [PPL_W-1:0]  ppl_pick;
    logic [31:0]       preset_pick;
    int                frozen_left;
    int                mode;
    plan = '{
      '{ROW_SAMPLE, CFG_PPL, 32'd0, 16'h0000, 1'b1, '{1'b0, 16'h0000, 32'd0, 32'd0}},
      '{ROW_SAMPLE, CFG_PPL, 32'd1, 16'hFFFF, 1'b1, '{1'b1, 16'hFFFF, 32'd131070, 32'd0}},
      '{ROW_SAMPLE, CFG_PPL, 32'd2, 16'h0000, 1'b1, '{1'b1, 16'h0001, 32'd131072, 32'd0}},
      '{ROW_CFG, CFG_PPL, 32'd1, 16'h0000, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'd3, 16'h0003, 1'b1, '{1'b1, 16'h0003, 32'd134072, 32'd0}},
      '{ROW_CFG, CFG_PPL, 32'hFFFF_FFFF, 16'h0000, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'd100, 16'h0004, 1'b1, '{1'b1, 16'h0001, 32'd134072, 32'd0}},
      // carry of 1000 left above the new setting
      '{ROW_CFG, CFG_PPL, 32'd7, 16'h0000, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'd100, 16'h0004, 1'b1, '{1'b0, 16'h0000, 32'd134214, 32'd0}},
      '{ROW_CFG, CFG_PRESET, 32'hFFFF_FFF0, 16'h0000, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'hFFFF_FFF0, 16'h0100, 1'b0, '0},
      '{ROW_CFG, 8'd2, 32'h1234_5678, 16'h0000, 1'b0, '0},
      '{ROW_CFG, 8'hFF, 32'hFFFF_FFFF, 16'h0000, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'hFFFF_FFF8, 16'h0200, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'hFFFF_FFFF, 16'h0300, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'd0, 16'h0400, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'd0, 16'h0500, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'd0, 16'h0600, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'd0, 16'h0700, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'd0, 16'h0800, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'd0, 16'h0900, 1'b0, '0},
      // window full with zero interval
      '{ROW_SAMPLE, CFG_PPL, 32'd0, 16'h0A00, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'd1, 16'hFFFF, 1'b0, '0},
      // flow above the output range
      '{ROW_SAMPLE, CFG_PPL, 32'd16, 16'hFFFF, 1'b0, '0},
      '{ROW_CFG, CFG_PPL, 32'd0, 16'h0000, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'h4000_0000, 16'h0000, 1'b0, '0},
      '{ROW_SAMPLE, CFG_PPL, 32'h8000_0000, 16'h1234, 1'b0, '0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_register(plan[i].cfg_index, plan[i].word);
      end else begin
        offer_sample(plan[i].count, plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    meter_count = 16'h1234;
    meter_tick = $urandom;
    frozen_left = 0;
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: ppl_pick = '0;
        1: ppl_pick = 16'd1;
        2: ppl_pick = 16'hFFFF;
        3: ppl_pick = 16'($urandom_range(2, 40));
        4: ppl_pick = 16'd500;
        default: ppl_pick = 16'($urandom_range(1, 65535));
      endcase
      case (phase)
        0: preset_pick = '0;
        1: preset_pick = '1;
        default: preset_pick = $urandom;
      endcase
      write_register(CFG_PPL, {16'($urandom), ppl_pick});
      write_register(CFG_PRESET, preset_pick);
      write_register(8'($urandom_range(2, 255)), $urandom);
      calm = (phase == 3);
      for (int n = 0; n < 200; n++) begin
        if (phase == 2 && n == 100) settle();
        if (frozen_left != 0) begin
          frozen_left--;
        end else begin
          mode = $urandom_range(99);
          if (mode < 2) begin
            // meter stops: no pulses, same time stamp
            frozen_left = 18;
          end else if (mode < 70) begin
            meter_count += 16'($urandom_range(0, 400));
            meter_tick += $urandom_range(0, 1500);
          end else if (mode < 80) begin
            meter_count += 16'($urandom);
            meter_tick += $urandom_range(1, 20);
          end else if (mode < 88) begin
            meter_count += 16'($urandom_range(0, 50));
          end else if (mode < 95) begin
            meter_count = 16'($urandom);
            meter_tick = $urandom;
          end else begin
            meter_tick += $urandom_range(0, 100000);
          end
        end
        offer_sample(meter_count, meter_tick, 1'b0, '0);
      end
    end
    calm = 1'b0;

    settle();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
